@@ rtl/stop_table_zoom_interpolator_core_defines.svh @@
// ----------------------------------------------------------------------------
// Stop table interpolator assertion macros
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef STOP_TABLE_ZOOM_INTERPOLATOR_CORE_DEFINES_SVH
`define STOP_TABLE_ZOOM_INTERPOLATOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define STZI_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("stzi port check failed");

// Next-cycle implication, disabled during reset
`define STZI_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("stzi port check failed");

`endif

@@ rtl/stzi_pkg.sv @@
// ----------------------------------------------------------------------------
// Stop table interpolator package
// Word types, codes, state encoding and the exp2 root table.
// ----------------------------------------------------------------------------
package stzi_pkg;

	localparam int MAX_STOPS_DEF = 8;
	localparam int EXP_STEPS     = 26;

	localparam logic [15:0] BASE_ONE = 16'd4096;
	localparam logic [30:0] ONE_Q30  = 31'h4000_0000;
	localparam logic [31:0] VALUE_ONE = 32'h0001_0000;

	// Input actions
	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_EVAL  = 1'b1;

	// Bracket kinds
	localparam logic [2:0] KIND_INTERP = 3'd0;
	localparam logic [2:0] KIND_EQUAL  = 3'd1;
	localparam logic [2:0] KIND_ABOVE  = 3'd2;
	localparam logic [2:0] KIND_BELOW  = 3'd3;
	localparam logic [2:0] KIND_NONE   = 3'd4;

	// Configuration register indexes
	localparam logic [1:0] CFG_CURVE_BASE   = 2'd0;
	localparam logic [1:0] CFG_STOPS_IN_USE = 2'd1;

	typedef struct packed {
		logic               action;
		logic [2:0]         stop_index;
		logic [15:0]        stop_zoom;
		logic signed [31:0] stop_value;
		logic [15:0]        query_zoom;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] result_value;
		logic [2:0]         bracket_kind;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_SCAN, ST_DECIDE, ST_LOG, ST_MAG, ST_EF, ST_EXPI_F, ST_EXP_F,
		ST_EXPI_A, ST_EXP_A, ST_NUMDEN, ST_DIVI, ST_DIV, ST_FMUL, ST_FINISH
	} stzi_state_t;

	typedef struct packed {
		logic write;
		logic load;
		logic scan;
		logic log_init;
		logic log_step;
		logic mag;
		logic ef;
		logic exp_init;
		logic exp_sel;
		logic exp_step;
		logic store_f;
		logic store_a;
		logic div_init;
		logic div_step;
		logic fmul;
		logic out_load;
	} stzi_cmd_t;

	typedef struct packed {
		logic scan_end;
		logic both;
		logic equal;
		logic linear;
		logic log_last;
		logic exp_last;
		logic div_last;
	} stzi_status_t;

	typedef logic [30:0] root_t;
	typedef root_t [EXP_STEPS:0] root_tab_t;

	// Integer square root, bit pair per pass
	function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
		logic [63:0] x;
		logic [63:0] r;
		logic [63:0] b;
		x = x_in;
		r = 64'd0;
		b = 64'd1 << 62;
		for (int k = 0; k < 32; k++) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// Roots 2^(-2^-i) in Q1.30, each from the one before
	function automatic root_tab_t root_table();
		root_tab_t   t;
		logic [63:0] v;
		t[0] = ONE_Q30 >> 1;
		for (int i = 1; i <= EXP_STEPS; i++) begin
			v = isqrt64({33'd0, t[i-1]} << 30);
			t[i] = v[30:0];
		end
		return t;
	endfunction

	localparam root_tab_t ROOTS = root_table();

endpackage

@@ rtl/stop_table_zoom_interpolator_core.sv @@
// ----------------------------------------------------------------------------
// Stop table zoom interpolator core
// Piecewise linear or exponential interpolation over a table of zoom stops.
// ----------------------------------------------------------------------------
// A stop write word is taken in the idle state and yields no result. An
// evaluate word is handled one at a time: a scan of the first stops_in_use
// entries, then with both bracket stops found a linear fraction from a
// serial restoring divide. An exponential fraction adds log2 by repeated
// squaring and two 26-step exp2 passes on one shared multiplier before the
// divide. Results with no interpolation pass from the scan through a decide
// state to the finish state. The result sits in an output register until
// taken; a new word is accepted once the result of the previous one has
// been loaded there.
module stop_table_zoom_interpolator_core
	import stzi_pkg::*;
#(
	parameter int MAX_STOPS = MAX_STOPS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  in_item_t    item,
	output logic        result_valid,
	input  logic        result_ready,
	output out_item_t   result,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	stzi_cmd_t    cmd;
	stzi_status_t status;

	// Registers take a write word in any cycle
	assign cfg_ready = 1'b1;

	stzi_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_action  (item.action),
		.item_ready   (item_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.status       (status),
		.cmd          (cmd)
	);

	stzi_datapath #(
		.MAX_STOPS (MAX_STOPS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.status    (status),
		.result    (result)
	);

endmodule

@@ rtl/stzi_ctrl.sv @@
// ----------------------------------------------------------------------------
// Stop table interpolator controller
// Sequences scan, log, exp, divide and output steps of one evaluate word.
// ----------------------------------------------------------------------------
module stzi_ctrl
	import stzi_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         item_valid,
	input  logic         item_action,
	output logic         item_ready,
	output logic         result_valid,
	input  logic         result_ready,
	input  stzi_status_t status,
	output stzi_cmd_t    cmd
);

	stzi_state_t state_q, state_d;
	logic        res_valid_q;
	logic        can_load;

	assign can_load     = !res_valid_q || result_ready;
	assign item_ready   = (state_q == ST_IDLE);
	assign result_valid = res_valid_q;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid && item_action == ACT_EVAL) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (status.scan_end) state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (!status.both || status.equal) state_d = ST_FINISH;
				else if (status.linear)           state_d = ST_DIVI;
				else                              state_d = ST_LOG;
			end
			ST_LOG: begin
				if (status.log_last) state_d = ST_MAG;
			end
			ST_MAG:    state_d = ST_EF;
			ST_EF:     state_d = ST_EXPI_F;
			ST_EXPI_F: state_d = ST_EXP_F;
			ST_EXP_F: begin
				if (status.exp_last) state_d = ST_EXPI_A;
			end
			ST_EXPI_A: state_d = ST_EXP_A;
			ST_EXP_A: begin
				if (status.exp_last) state_d = ST_NUMDEN;
			end
			ST_NUMDEN: state_d = ST_DIVI;
			ST_DIVI:   state_d = ST_DIV;
			ST_DIV: begin
				if (status.div_last) state_d = ST_FMUL;
			end
			ST_FMUL:   state_d = ST_FINISH;
			ST_FINISH: begin
				if (can_load) state_d = ST_IDLE;
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	// Commands
	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.load  = item_valid && item_action == ACT_EVAL;
				cmd.write = item_valid && item_action == ACT_WRITE;
			end
			ST_SCAN:   cmd.scan = !status.scan_end;
			ST_DECIDE: cmd.log_init = status.both && !status.equal && !status.linear;
			ST_LOG:    cmd.log_step = 1'b1;
			ST_MAG:    cmd.mag = 1'b1;
			ST_EF:     cmd.ef = 1'b1;
			ST_EXPI_F: cmd.exp_init = 1'b1;
			ST_EXP_F:  cmd.exp_step = 1'b1;
			ST_EXPI_A: begin
				cmd.store_f  = 1'b1;
				cmd.exp_init = 1'b1;
				cmd.exp_sel  = 1'b1;
			end
			ST_EXP_A:  cmd.exp_step = 1'b1;
			ST_NUMDEN: cmd.store_a = 1'b1;
			ST_DIVI:   cmd.div_init = 1'b1;
			ST_DIV:    cmd.div_step = 1'b1;
			ST_FMUL:   cmd.fmul = 1'b1;
			ST_FINISH: cmd.out_load = can_load;
			default:   cmd = '0;
		endcase
	end

	// State and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load)       res_valid_q <= 1'b1;
			else if (result_ready)  res_valid_q <= 1'b0;
		end
	end

endmodule

@@ rtl/stzi_datapath.sv @@
// ----------------------------------------------------------------------------
// Stop table interpolator datapath
// Stop tables, bracket scan, log2/exp2 iterations, serial divider, output.
// ----------------------------------------------------------------------------
module stzi_datapath
	import stzi_pkg::*;
#(
	parameter int MAX_STOPS = MAX_STOPS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  in_item_t     item,
	input  logic         cfg_valid,
	input  logic [1:0]   cfg_index,
	input  logic [15:0]  cfg_data,
	input  stzi_cmd_t    cmd,
	output stzi_status_t status,
	output out_item_t    result
);

	localparam int IDX_W = (MAX_STOPS > 1) ? $clog2(MAX_STOPS) : 1;
	localparam int CNT_W = $clog2(MAX_STOPS + 1);

	logic [15:0]        zoom_tab_q [MAX_STOPS];
	logic signed [31:0] val_tab_q  [MAX_STOPS];

	logic [15:0]        base_q;
	logic [3:0]         stops_q;

	logic [CNT_W-1:0]   cnt_q;
	logic [CNT_W-1:0]   n_lim;
	logic [IDX_W-1:0]   wr_addr;
	logic [15:0]        z_q;
	logic               lo_q, hi_q;
	logic [15:0]        lo_z_q, hi_z_q;
	logic signed [31:0] lo_v_q, hi_v_q;
	logic [15:0]        sz;
	logic signed [31:0] sv;
	logic [15:0]        p, d;

	logic [5:0]         it_q;
	logic [15:0]        base_eff;
	logic [3:0]         msb;
	logic [3:0]         msb_q;
	logic [30:0]        m_q;
	logic [61:0]        msq;
	logic [31:0]        sq;
	logic [15:0]        frac_q;
	logic [19:0]        mag_q;
	logic               pos_q;
	logic [35:0]        e_q, f_q;

	logic [35:0]        y_sel;
	logic [30:0]        acc_q;
	logic [25:0]        yf_q;
	logic [9:0]         yn_q;
	logic [61:0]        amul;
	logic [30:0]        exp_res;
	logic [30:0]        ef_q, ea_q;

	logic [30:0]        num_a, num_b, den;
	logic               degen;
	logic [46:0]        dvd_q;
	logic [30:0]        dvs_q;
	logic [30:0]        rem_q;
	logic [31:0]        rem_sh;
	logic               rem_ge;
	logic [31:0]        rem_sub;

	logic [15:0]        t_val;
	logic signed [32:0] diff;
	logic signed [49:0] prod_q;
	logic signed [49:0] shr;

	// Table write address and scan limit
	assign wr_addr = IDX_W'({{IDX_W{1'b0}}, item.stop_index});
	assign n_lim   = (int'(stops_q) > MAX_STOPS) ? CNT_W'(MAX_STOPS) : CNT_W'(stops_q);
	assign sz      = zoom_tab_q[cnt_q[IDX_W-1:0]];
	assign sv      = val_tab_q[cnt_q[IDX_W-1:0]];
	assign p       = z_q - lo_z_q;
	assign d       = hi_z_q - lo_z_q;

	// Leading one of the base
	assign base_eff = (base_q == 16'd0) ? 16'd1 : base_q;
	always_comb begin
		msb = 4'd0;
		for (int k = 0; k < 16; k++) begin
			if (base_eff[k]) msb = 4'(k);
		end
	end

	assign msq = {31'd0, m_q} * {31'd0, m_q};
	assign sq  = msq[61:30];

	// Exponent choice and root multiply
	assign y_sel   = !cmd.exp_sel ? f_q : (pos_q ? f_q - e_q : e_q);
	assign amul    = {31'd0, acc_q} * {31'd0, ROOTS[it_q[4:0] + 5'd1]};
	assign exp_res = (yn_q > 10'd30) ? 31'd0 : (acc_q >> yn_q[4:0]);

	// Fraction operands
	assign num_a = pos_q ? ea_q : ONE_Q30;
	assign num_b = pos_q ? ef_q : ea_q;
	assign den   = ONE_Q30 - ef_q;
	assign degen = (num_a <= num_b) || (den == 31'd0);

	assign rem_sh  = {rem_q, dvd_q[46]};
	assign rem_ge  = rem_sh >= {1'b0, dvs_q};
	assign rem_sub = rem_sh - {1'b0, dvs_q};

	assign t_val = (|dvd_q[46:16]) ? 16'hFFFF : dvd_q[15:0];
	assign diff  = {hi_v_q[31], hi_v_q} - {lo_v_q[31], lo_v_q};
	assign shr   = prod_q >>> 16;

	assign status.scan_end = (cnt_q == n_lim);
	assign status.both     = lo_q && hi_q;
	assign status.equal    = (lo_z_q == hi_z_q) || (lo_v_q == hi_v_q);
	assign status.linear   = (base_q == BASE_ONE);
	assign status.log_last = (it_q == 6'd15);
	assign status.exp_last = (it_q == 6'(EXP_STEPS - 1));
	assign status.div_last = (it_q == 6'd46);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= BASE_ONE;
			stops_q <= 4'd0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_CURVE_BASE:   base_q  <= cfg_data;
				CFG_STOPS_IN_USE: stops_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// Stop tables
	always_ff @(posedge clk) begin
		if (cmd.write && int'(item.stop_index) < MAX_STOPS) begin
			zoom_tab_q[wr_addr] <= item.stop_zoom;
			val_tab_q[wr_addr]  <= item.stop_value;
		end
	end

	// Scan control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			lo_q  <= 1'b0;
			hi_q  <= 1'b0;
			it_q  <= 6'd0;
		end else begin
			if (cmd.load) begin
				cnt_q <= '0;
				lo_q  <= 1'b0;
				hi_q  <= 1'b0;
			end else if (cmd.scan) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (sz <= z_q && (!lo_q || lo_z_q < sz)) lo_q <= 1'b1;
				if (sz >= z_q && (!hi_q || hi_z_q > sz)) hi_q <= 1'b1;
			end
			if (cmd.log_init || cmd.exp_init || cmd.div_init) it_q <= 6'd0;
			else if (cmd.log_step || cmd.exp_step || cmd.div_step) it_q <= it_q + 6'd1;
		end
	end

	// Bracket payload
	always_ff @(posedge clk) begin
		if (cmd.load) z_q <= item.query_zoom;
		if (cmd.scan) begin
			if (sz <= z_q && (!lo_q || lo_z_q < sz)) begin
				lo_z_q <= sz;
				lo_v_q <= sv;
			end
			if (sz >= z_q && (!hi_q || hi_z_q > sz)) begin
				hi_z_q <= sz;
				hi_v_q <= sv;
			end
		end
	end

	// log2 of the base by repeated squaring
	always_ff @(posedge clk) begin
		if (cmd.log_init) begin
			m_q    <= 31'({15'd0, base_eff} << (5'd30 - {1'b0, msb}));
			msb_q  <= msb;
			frac_q <= 16'd0;
		end else if (cmd.log_step) begin
			m_q    <= sq[31] ? sq[31:1] : sq[30:0];
			frac_q <= {frac_q[14:0], sq[31]};
		end
		if (cmd.mag) begin
			pos_q <= (msb_q > 4'd12) || (msb_q == 4'd12 && frac_q != 16'd0);
			if (msb_q >= 4'd12) mag_q <= {2'd0, 2'(msb_q - 4'd12), frac_q};
			else                mag_q <= {4'd12 - msb_q, 16'd0} - {4'd0, frac_q};
		end
		if (cmd.ef) begin
			e_q <= {20'd0, p} * {16'd0, mag_q};
			f_q <= {20'd0, d} * {16'd0, mag_q};
		end
	end

	// exp2 of a negative exponent, one fraction bit per step
	always_ff @(posedge clk) begin
		if (cmd.store_f) ef_q <= exp_res;
		if (cmd.store_a) ea_q <= exp_res;
		if (cmd.exp_init) begin
			acc_q <= ONE_Q30;
			yf_q  <= y_sel[25:0];
			yn_q  <= y_sel[35:26];
		end else if (cmd.exp_step) begin
			if (yf_q[25]) acc_q <= amul[60:30];
			yf_q <= {yf_q[24:0], 1'b0};
		end
	end

	// Restoring divider, one quotient bit per step
	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			rem_q <= 31'd0;
			if (status.linear) begin
				dvd_q <= {15'd0, p, 16'd0};
				dvs_q <= {15'd0, d};
			end else if (degen) begin
				dvd_q <= 47'd0;
				dvs_q <= 31'd1;
			end else begin
				dvd_q <= {num_a - num_b, 16'd0};
				dvs_q <= den;
			end
		end else if (cmd.div_step) begin
			rem_q <= rem_ge ? rem_sub[30:0] : rem_sh[30:0];
			dvd_q <= {dvd_q[45:0], rem_ge};
		end
	end

	// Scale the difference and form the result word
	always_ff @(posedge clk) begin
		if (cmd.fmul) prod_q <= diff * $signed({1'b0, t_val});
		if (cmd.out_load) begin
			if (lo_q && hi_q) begin
				if (status.equal) begin
					result.result_value <= lo_v_q;
					result.bracket_kind <= KIND_EQUAL;
				end else begin
					result.result_value <= lo_v_q + shr[31:0];
					result.bracket_kind <= KIND_INTERP;
				end
			end else if (hi_q) begin
				result.result_value <= hi_v_q;
				result.bracket_kind <= KIND_ABOVE;
			end else if (lo_q) begin
				result.result_value <= lo_v_q;
				result.bracket_kind <= KIND_BELOW;
			end else begin
				result.result_value <= VALUE_ONE;
				result.bracket_kind <= KIND_NONE;
			end
		end
	end

endmodule

@@ rtl/stzi_checker.sv @@
// ----------------------------------------------------------------------------
// Stop table interpolator port checker
// Port-level properties over time, bound to the core.
// ----------------------------------------------------------------------------
`include "stop_table_zoom_interpolator_core_defines.svh"

module stzi_checker
	import stzi_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        item_valid,
	input logic        item_ready,
	input in_item_t    item,
	input logic        result_valid,
	input logic        result_ready,
	input out_item_t   result
);

	// Hold a stalled result word
	`STZI_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result))

	// Go busy after an evaluate word
	`STZI_ASSERT_NEXT(a_eval_busy, item_valid && item_ready && item.action == ACT_EVAL, !item_ready)

	// Stay ready after a stop write
	`STZI_ASSERT_NEXT(a_write_idle, item_valid && item_ready && item.action == ACT_WRITE, item_ready)

	// Kind stays within its codes
	`STZI_ASSERT_NOW(a_kind_range, result_valid, result.bracket_kind <= KIND_NONE)

endmodule

bind stop_table_zoom_interpolator_core stzi_checker u_stzi_checker (.*);

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Stop table zoom interpolator testbench
// Drives stop writes and evaluate words through several base and stop-count
// settings and under varied handshake idling. Each evaluate result is checked
// against an in-bench fixed-point interpolation predictor.
// ----------------------------------------------------------------------------
module tb;
	import stzi_pkg::*;

	// Predicts results and holds the words still owed by the block
	class interp_scoreboard;
		logic [15:0]  zoom_tab [8];
		logic [31:0]  value_tab [8];
		logic [15:0]  base_reg = BASE_ONE;
		logic [3:0]   count_reg = 4'd0;
		bit   [63:0]  roots [27];
		bit           roots_built = 0;
		out_item_t    owed [$];
		int           errs = 0;

		function bit [63:0] int_sqrt(bit [63:0] x);
			bit [63:0] r;
			bit [63:0] b;
			r = 0;
			b = 64'd1 << 62;
			for (int k = 0; k < 32; k++) begin
				if (x >= r + b) begin
					x = x - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
			return r;
		endfunction

		// 2^-y, y in Q.26, result in Q1.30
		function bit [63:0] pow2_neg(bit [63:0] y);
			bit [63:0] acc;
			bit [63:0] whole;
			if (!roots_built) begin
				roots[0] = 64'd1 << 29;
				for (int i = 1; i <= 26; i++)
					roots[i] = int_sqrt(roots[i-1] << 30);
				roots_built = 1;
			end
			whole = y >> 26;
			acc = 64'd1 << 30;
			for (int i = 1; i <= 26; i++)
				if (y[26-i])
					acc = (acc * roots[i]) >> 30;
			if (whole > 30)
				return 0;
			return acc >> whole;
		endfunction

		// log2(base / 1.0) in signed Q.16
		function longint log2_of_base(logic [15:0] b);
			int          msb;
			bit   [63:0] m;
			longint      frac;
			msb = 15;
			frac = 0;
			if (b == 0)
				b = 1;
			while (!b[msb])
				msb--;
			m = 64'(b) << (30 - msb);
			for (int i = 15; i >= 0; i--) begin
				m = (m * m) >> 30;
				if (m >= (64'd1 << 31)) begin
					m = m >> 1;
					frac = frac | (longint'(1) << i);
				end
			end
			return longint'(msb - 12) * 65536 + frac;
		endfunction

		function bit [63:0] curve_fraction(bit [63:0] p, bit [63:0] d);
			longint    lg;
			bit [63:0] mag;
			bit [63:0] num_a;
			bit [63:0] num_b;
			bit [63:0] den;
			lg = log2_of_base(base_reg);
			mag = (lg < 0) ? -lg : lg;
			if (lg > 0) begin
				num_a = pow2_neg(d * mag - p * mag);
				num_b = pow2_neg(d * mag);
			end else begin
				num_a = 64'd1 << 30;
				num_b = pow2_neg(p * mag);
			end
			den = (64'd1 << 30) - pow2_neg(d * mag);
			if (num_a <= num_b || den == 0)
				return 0;
			return ((num_a - num_b) << 16) / den;
		endfunction

		function void set_reg(logic [1:0] idx, logic [15:0] data);
			if (idx == CFG_CURVE_BASE)
				base_reg = data;
			else if (idx == CFG_STOPS_IN_USE)
				count_reg = data[3:0];
		endfunction

		// Take one accepted input word
		function void note_item(in_item_t it);
			int          n;
			bit          lo;
			bit          hi;
			logic [15:0] lo_z;
			logic [15:0] hi_z;
			logic [31:0] lo_v;
			logic [31:0] hi_v;
			bit   [63:0] t;
			longint      prod;
			out_item_t   r;
			if (it.action == ACT_WRITE) begin
				zoom_tab[it.stop_index] = it.stop_zoom;
				value_tab[it.stop_index] = it.stop_value;
				return;
			end
			n = (count_reg > 8) ? 8 : count_reg;
			lo = 0;
			hi = 0;
			for (int i = 0; i < n; i++) begin
				if (zoom_tab[i] <= it.query_zoom && (!lo || lo_z < zoom_tab[i])) begin
					lo = 1;
					lo_z = zoom_tab[i];
					lo_v = value_tab[i];
				end
				if (zoom_tab[i] >= it.query_zoom && (!hi || hi_z > zoom_tab[i])) begin
					hi = 1;
					hi_z = zoom_tab[i];
					hi_v = value_tab[i];
				end
			end
			if (lo && hi) begin
				if (lo_z == hi_z || lo_v == hi_v) begin
					r.result_value = lo_v;
					r.bracket_kind = KIND_EQUAL;
				end else begin
					if (base_reg == BASE_ONE)
						t = (64'(it.query_zoom - lo_z) << 16) / 64'(hi_z - lo_z);
					else
						t = curve_fraction(64'(it.query_zoom - lo_z), 64'(hi_z - lo_z));
					if (t > 65535)
						t = 65535;
					prod = (longint'($signed(hi_v)) - longint'($signed(lo_v))) * longint'(t);
					r.result_value = 32'(longint'($signed(lo_v)) + (prod >>> 16));
					r.bracket_kind = KIND_INTERP;
				end
			end else if (hi) begin
				r.result_value = hi_v;
				r.bracket_kind = KIND_ABOVE;
			end else if (lo) begin
				r.result_value = lo_v;
				r.bracket_kind = KIND_BELOW;
			end else begin
				r.result_value = VALUE_ONE;
				r.bracket_kind = KIND_NONE;
			end
			owed.push_back(r);
		endfunction

		// Compare one accepted result word with the oldest prediction
		function void check_result(out_item_t got);
			out_item_t want;
			if (owed.size() == 0) begin
				$error("unexpected result word value %0d kind %0d",
					got.result_value, got.bracket_kind);
				errs++;
				return;
			end
			want = owed.pop_front();
			if (got.result_value !== want.result_value) begin
				$error("result_value expected %0d actual %0d",
					want.result_value, got.result_value);
				errs++;
			end
			if (got.bracket_kind !== want.bracket_kind) begin
				$error("bracket_kind expected %0d actual %0d",
					want.bracket_kind, got.bracket_kind);
				errs++;
			end
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        item_valid = 0;
	logic        item_ready;
	in_item_t    item = '0;
	logic        result_valid;
	logic        result_ready = 0;
	out_item_t   result;
	logic        cfg_valid = 0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	interp_scoreboard sb = new;
	int send_idle = 0;
	int recv_idle = 0;
	int quiet_cycles = 0;

	stop_table_zoom_interpolator_core uut (.*);

	always #5 clk = ~clk;

	// Randomize receiver backpressure
	always @(posedge clk) begin
		result_ready <= ($urandom_range(99) >= recv_idle);
	end

	// Check result words
	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready)
			sb.check_result(result);
	end

	// Abort when nothing moves for too long
	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready)
				|| (cfg_valid && cfg_ready) || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= 20000) begin
			$display("stop_table_zoom_interpolator_core verification failed");
			$finish;
		end
	end

	task automatic send_word(in_item_t it);
		while ($urandom_range(99) < send_idle) begin
			item_valid <= 0;
			@(posedge clk);
		end
		item_valid <= 1;
		item <= it;
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
		sb.note_item(it);
	endtask

	task automatic write_stop(int idx, logic [15:0] z, logic [31:0] v);
		in_item_t it;
		it = '0;
		it.action = ACT_WRITE;
		it.stop_index = 3'(idx);
		it.stop_zoom = z;
		it.stop_value = v;
		it.query_zoom = 16'($urandom);
		send_word(it);
	endtask

	task automatic eval_at(logic [15:0] q);
		in_item_t it;
		it = '0;
		it.action = ACT_EVAL;
		it.stop_index = 3'($urandom);
		it.stop_zoom = 16'($urandom);
		it.stop_value = $urandom;
		it.query_zoom = q;
		send_word(it);
	endtask

	// Hold until the block is idle, then let a write's tail finish
	task automatic drain();
		item_valid <= 0;
		@(posedge clk);
		while (sb.owed.size() > 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] data);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.set_reg(idx, data);
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	task automatic random_word();
		int          k;
		logic [15:0] z;
		logic [31:0] v;
		k = $urandom_range(7);
		if ($urandom_range(99) < 30) begin
			z = ($urandom_range(1)) ? 16'($urandom_range(8) * 1024) : 16'($urandom);
			v = ($urandom_range(4) == 0) ? sb.value_tab[$urandom_range(7)] : $urandom;
			write_stop($urandom_range(7), z, v);
		end else begin
			if ($urandom_range(1))
				z = sb.zoom_tab[k] + 16'($signed($urandom_range(8)) - 4);
			else
				z = 16'($urandom);
			eval_at(z);
		end
	endtask

	logic [15:0] phase_base [8] = '{16'd4096, 16'd1, 16'd65535, 16'd0,
		16'd2048, 16'd8192, 16'd5000, 16'd4096};
	logic [15:0] phase_count [8] = '{16'd8, 16'd15, 16'd3, 16'd8,
		16'd1, 16'd8, 16'd5, 16'd8};

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: empty table, then a full table with edge zooms and values
		eval_at(16'h0000);
		eval_at(16'hFFFF);
		write_stop(0, 16'd1024, 32'h8000_0000);
		write_stop(1, 16'd2048, 32'h7FFF_FFFF);
		write_stop(2, 16'd2048, 32'h0000_0000);
		write_stop(3, 16'd4096, 32'h7FFF_FFFF);
		write_stop(4, 16'd8192, 32'h0001_0000);
		write_stop(5, 16'd12288, 32'h0001_0000);
		write_stop(6, 16'hFFFF, 32'hFFFF_FFFF);
		write_stop(7, 16'h0000, 32'h1234_5678);
		drain();
		write_reg(CFG_STOPS_IN_USE, 16'd8);
		eval_at(16'h0000);
		eval_at(16'd512);
		eval_at(16'd1536);
		eval_at(16'd2048);
		eval_at(16'd3000);
		eval_at(16'd10000);
		eval_at(16'hFFFF);
		drain();
		write_reg(CFG_STOPS_IN_USE, 16'd2);
		eval_at(16'd0);
		eval_at(16'd60000);
		drain();
		write_reg(CFG_STOPS_IN_USE, 16'd1);
		eval_at(16'd100);
		eval_at(16'd1024);

		// Random phases over base and stop-count settings
		for (int ph = 0; ph < 8; ph++) begin
			drain();
			send_idle = (ph < 3) ? 16 : (ph < 6) ? 71 : 0;
			recv_idle = (ph < 3) ? 71 : (ph < 6) ? 16 : 0;
			write_reg(CFG_CURVE_BASE, (ph == 6) ? 16'($urandom) : phase_base[ph]);
			write_reg(CFG_STOPS_IN_USE,
				(ph == 6) ? 16'($urandom_range(15)) : phase_count[ph]);
			repeat (50)
				random_word();
		end

		drain();
		if (sb.errs == 0)
			$display("stop_table_zoom_interpolator_core verification clean");
		else
			$display("stop_table_zoom_interpolator_core verification failed");
		$finish;
	end
endmodule
